// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands shared by the steering RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/lfps_pkg.sv =====
// ----------------------------------------------------------------------------
// lfps_pkg
// Shared widths, constants, register codes and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package lfps_pkg;

  localparam int SENSOR_COUNT   = 6;
  localparam int POS_BITS       = 13;
  localparam int TH_BITS        = 10;
  localparam int GAIN_BITS      = 8;
  localparam int SPEED_BITS     = 8;
  localparam int ERR_BITS       = 14;
  localparam int INT_BITS       = 32;
  localparam int DIFF_BITS      = 20;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 13;

  localparam int WEIGHT_STEP    = 1000;
  localparam int POS_MAX        = (SENSOR_COUNT - 1) * WEIGHT_STEP;
  localparam int POS_MID        = POS_MAX / 2;

  // integral / 10000 as (mag >> 4) / 625 by reciprocal multiply
  localparam int INTEG_DIV       = 10000;
  localparam int INTEG_PRE_SHIFT = 4;
  localparam int INTEG_RCP_BITS  = 28;
  localparam int INTEG_RCP_SHIFT = 37;
  localparam logic [INTEG_RCP_BITS-1:0] INTEG_RCP = 28'd219902326;
  localparam int INTEG_Q_BITS    = 18;

  localparam logic [POS_BITS-1:0]   SETPOINT_RST   = POS_BITS'(2600);
  localparam logic [GAIN_BITS-1:0]  GAIN_RST       = GAIN_BITS'(40);
  localparam logic [SPEED_BITS-1:0] TOP_SPEED_RST  = SPEED_BITS'(100);
  localparam logic [TH_BITS-1:0]    LINE_TH_RST    = TH_BITS'(200);
  localparam logic [TH_BITS-1:0]    NOISE_TH_RST   = TH_BITS'(50);

  localparam logic [CFG_INDEX_BITS-1:0] CFG_SETPOINT  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_GAIN_DIV  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TOP_SPEED = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LINE_TH   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_NOISE_TH  = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MERGE,
    ST_CENT,
    ST_CWAIT,
    ST_PID,
    ST_PWAIT,
    ST_SUM,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/lfps_lane.sv =====
// ----------------------------------------------------------------------------
// lfps_lane
// One sensor lane: threshold compares and weighted product, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lfps_lane #(
  parameter int SAMPLE_BITS = 10,
  parameter int WEIGHT      = 0
) (
  input  wire logic                                     clk,
  input  wire logic                                     load,
  input  wire logic [SAMPLE_BITS-1:0]                   sample,
  input  wire logic [lfps_pkg::TH_BITS-1:0]             line_threshold,
  input  wire logic [lfps_pkg::TH_BITS-1:0]             noise_threshold,
  output logic                                          seen,
  output logic [SAMPLE_BITS-1:0]                        value,
  output logic [SAMPLE_BITS+lfps_pkg::POS_BITS-1:0]     product
);
  import lfps_pkg::*;

  localparam int CW = (SAMPLE_BITS > TH_BITS) ? SAMPLE_BITS : TH_BITS;
  localparam int PW = SAMPLE_BITS + POS_BITS;

  logic          above_line;
  logic          above_noise;
  logic [PW-1:0] weighted;

  assign above_line  = CW'(sample) > CW'(line_threshold);
  assign above_noise = CW'(sample) > CW'(noise_threshold);
  assign weighted    = PW'(sample) * PW'(WEIGHT);

  always_ff @(posedge clk) begin
    if (load) begin
      seen    <= above_line;
      value   <= above_noise ? sample : '0;
      product <= above_noise ? weighted : '0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lfps_merge.sv =====
// ----------------------------------------------------------------------------
// lfps_merge
// Combines lane results: line-seen flag, sample total and weighted sum.
// ----------------------------------------------------------------------------
`default_nettype none

module lfps_merge #(
  parameter  int LANES = 6,
  parameter  int VW    = 10,
  parameter  int PW    = 23,
  localparam int TW    = VW + $clog2(LANES),
  localparam int WW    = PW + $clog2(LANES)
) (
  input  wire logic                      clk,
  input  wire logic                      load,
  input  wire logic [LANES-1:0]          seen_in,
  input  wire logic [LANES-1:0][VW-1:0]  value_in,
  input  wire logic [LANES-1:0][PW-1:0]  product_in,
  output logic                           seen,
  output logic [TW-1:0]                  total,
  output logic [WW-1:0]                  wsum
);

  logic [TW-1:0] total_next;
  logic [WW-1:0] wsum_next;

  always_comb begin
    total_next = '0;
    wsum_next  = '0;
    for (int i = 0; i < LANES; i++) begin
      total_next = total_next + TW'(value_in[i]);
      wsum_next  = wsum_next + WW'(product_in[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      seen  <= |seen_in;
      total <= total_next;
      wsum  <= wsum_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lfps_div.sv =====
// ----------------------------------------------------------------------------
// lfps_div
// Restoring serial divider, one quotient bit per cycle.
// Dividend must be below divisor * 2**QW.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lfps_div #(
  parameter int DW = 8,
  parameter int QW = 13
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DW+QW-1:0] dividend,
  input  wire logic [DW-1:0]    divisor,
  output logic                  busy,
  output logic [QW-1:0]         quotient
);

  localparam int CNT_W = $clog2(QW + 1);

  logic [DW-1:0]    rem;
  logic [DW-1:0]    divisor_q;
  logic [QW-1:0]    quo;
  logic [CNT_W-1:0] cnt;
  logic [DW:0]      shifted;
  logic [DW:0]      reduced;
  logic             take;

  assign shifted  = {rem, quo[QW-1]};
  assign take     = shifted >= {1'b0, divisor_q};
  assign reduced  = shifted - {1'b0, divisor_q};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(QW);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem       <= dividend[DW+QW-1:QW];
      quo       <= dividend[QW-1:0];
      divisor_q <= divisor;
    end else if (busy) begin
      rem <= take ? reduced[DW-1:0] : shifted[DW-1:0];
      quo <= {quo[QW-2:0], take};
    end
  end

  `ASSERT_ALWAYS(a_rem_below_div, !busy || (rem < divisor_q), "partial remainder not below divisor")

endmodule

`default_nettype wire

// ===== rtl/line_follow_pid_steering.sv =====
// ----------------------------------------------------------------------------
// line_follow_pid_steering
// Sequence: the lanes load the samples, then merge, then the 13-step centroid
// divider (skipped when no centroid is formed: line lost or nothing above the
// noise threshold), then the 13-step proportional divider, sum and output.
// Only one item is in flight; a result_stall on a held result also holds it.
// Result register frees the input.
// Reset: synchronous; configuration registers return to defaults, PID state clears to zero.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module line_follow_pid_steering #(
  parameter int SAMPLE_BITS = 10
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  sample_valid,
  output logic                                       sample_stall,
  input  wire logic [SAMPLE_BITS-1:0]                sample_a,
  input  wire logic [SAMPLE_BITS-1:0]                sample_b,
  input  wire logic [SAMPLE_BITS-1:0]                sample_c,
  input  wire logic [SAMPLE_BITS-1:0]                sample_d,
  input  wire logic [SAMPLE_BITS-1:0]                sample_e,
  input  wire logic [SAMPLE_BITS-1:0]                sample_f,
  output logic                                       result_valid,
  input  wire logic                                  result_stall,
  output logic [lfps_pkg::SPEED_BITS-1:0]            left_speed,
  output logic [lfps_pkg::SPEED_BITS-1:0]            right_speed,
  output logic [lfps_pkg::POS_BITS-1:0]              line_position,
  output logic                                       line_seen,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [lfps_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [lfps_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
  import lfps_pkg::*;

  localparam int PROD_W = SAMPLE_BITS + POS_BITS;
  localparam int TOT_W  = SAMPLE_BITS + $clog2(SENSOR_COUNT);
  localparam int WSUM_W = PROD_W + $clog2(SENSOR_COUNT);
  localparam int DH_W   = ERR_BITS + 2;

  // configuration
  logic [POS_BITS-1:0]   setpoint;
  logic [GAIN_BITS-1:0]  gain_divider;
  logic [SPEED_BITS-1:0] top_speed;
  logic [TH_BITS-1:0]    line_threshold;
  logic [TH_BITS-1:0]    noise_threshold;

  // loop state
  logic [POS_BITS-1:0]   last_position;
  logic [ERR_BITS-1:0]   last_error;
  logic [INT_BITS-1:0]   error_integral;

  state_t state, state_next;

  logic lane_load, merge_load, pos_load, cdiv_start, pid_load, sum_load, out_load;
  logic out_free;

  logic [SENSOR_COUNT-1:0][SAMPLE_BITS-1:0] samples;
  logic [SENSOR_COUNT-1:0]                  lane_seen;
  logic [SENSOR_COUNT-1:0][SAMPLE_BITS-1:0] lane_value;
  logic [SENSOR_COUNT-1:0][PROD_W-1:0]      lane_product;

  logic                m_seen;
  logic [TOT_W-1:0]    m_total;
  logic [WSUM_W-1:0]   m_wsum;

  logic                cdiv_busy, pdiv_busy;
  logic [POS_BITS-1:0] cdiv_q;
  logic [POS_BITS-1:0] pdiv_q;
  logic [INTEG_Q_BITS-1:0] idiv_q;
  logic [INT_BITS-1:0]     integ_mag_q;
  logic [2*INTEG_RCP_BITS-1:0] integ_prod;

  logic [POS_BITS-1:0]  pos, pos_next;
  logic [ERR_BITS-1:0]  err_c;
  logic [ERR_BITS-1:0]  err_abs;
  logic [ERR_BITS:0]    deriv;
  logic [ERR_BITS+2:0]  d3;
  logic [ERR_BITS+2:0]  d3r;
  logic [INT_BITS:0]    integ_sum;
  logic [INT_BITS-1:0]  integ_sat;
  logic [INT_BITS-1:0]  integ_mag;
  logic [GAIN_BITS-1:0] gain_eff;

  logic                 err_neg;
  logic                 integ_neg;
  logic [DH_W-1:0]      dh;

  logic [DIFF_BITS-1:0] q1e, q2e, q1s, q2s, dh_ext, diff_next;
  logic signed [DIFF_BITS-1:0] diff;
  logic signed [DIFF_BITS-1:0] top_s;
  logic signed [DIFF_BITS-1:0] clamp;
  logic [SPEED_BITS-1:0] left_next, right_next;

  assign samples[0] = sample_a;
  assign samples[1] = sample_b;
  assign samples[2] = sample_c;
  assign samples[3] = sample_d;
  assign samples[4] = sample_e;
  assign samples[5] = sample_f;

  assign cfg_ready    = 1'b1;
  assign sample_stall = (state != ST_IDLE);
  assign lane_load    = sample_valid && !sample_stall;
  assign out_free     = !result_valid || !result_stall;

  // ---------------- lanes and merge ----------------
  for (genvar i = 0; i < SENSOR_COUNT; i++) begin : g_lane
    lfps_lane #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .WEIGHT      (i * WEIGHT_STEP)
    ) u_lane (
      .clk             (clk),
      .load            (lane_load),
      .sample          (samples[i]),
      .line_threshold  (line_threshold),
      .noise_threshold (noise_threshold),
      .seen            (lane_seen[i]),
      .value           (lane_value[i]),
      .product         (lane_product[i])
    );
  end

  lfps_merge #(
    .LANES (SENSOR_COUNT),
    .VW    (SAMPLE_BITS),
    .PW    (PROD_W)
  ) u_merge (
    .clk        (clk),
    .load       (merge_load),
    .seen_in    (lane_seen),
    .value_in   (lane_value),
    .product_in (lane_product),
    .seen       (m_seen),
    .total      (m_total),
    .wsum       (m_wsum)
  );

  // ---------------- dividers ----------------
  lfps_div #(
    .DW (TOT_W),
    .QW (POS_BITS)
  ) u_cdiv (
    .clk      (clk),
    .rst      (rst),
    .start    (cdiv_start),
    .dividend (m_wsum),
    .divisor  (m_total),
    .busy     (cdiv_busy),
    .quotient (cdiv_q)
  );

  lfps_div #(
    .DW (GAIN_BITS),
    .QW (POS_BITS)
  ) u_pdiv (
    .clk      (clk),
    .rst      (rst),
    .start    (pid_load),
    .dividend ({{GAIN_BITS{1'b0}}, err_abs[POS_BITS-1:0]}),
    .divisor  (gain_eff),
    .busy     (pdiv_busy),
    .quotient (pdiv_q)
  );

  // ---------------- controller ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    merge_load = 1'b0;
    pos_load   = 1'b0;
    cdiv_start = 1'b0;
    pid_load   = 1'b0;
    sum_load   = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (sample_valid) state_next = ST_MERGE;
      end
      ST_MERGE: begin
        merge_load = 1'b1;
        state_next = ST_CENT;
      end
      ST_CENT: begin
        if (!m_seen || (m_total == '0)) begin
          pos_load   = 1'b1;
          state_next = ST_PID;
        end else begin
          cdiv_start = 1'b1;
          state_next = ST_CWAIT;
        end
      end
      ST_CWAIT: begin
        if (!cdiv_busy) begin
          pos_load   = 1'b1;
          state_next = ST_PID;
        end
      end
      ST_PID: begin
        pid_load   = 1'b1;
        state_next = ST_PWAIT;
      end
      ST_PWAIT: begin
        if (!pdiv_busy) state_next = ST_SUM;
      end
      ST_SUM: begin
        sum_load   = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint        <= SETPOINT_RST;
      gain_divider    <= GAIN_RST;
      top_speed       <= TOP_SPEED_RST;
      line_threshold  <= LINE_TH_RST;
      noise_threshold <= NOISE_TH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SETPOINT:  setpoint        <= cfg_data[POS_BITS-1:0];
        CFG_GAIN_DIV:  gain_divider    <= cfg_data[GAIN_BITS-1:0];
        CFG_TOP_SPEED: top_speed       <= cfg_data[SPEED_BITS-1:0];
        CFG_LINE_TH:   line_threshold  <= cfg_data[TH_BITS-1:0];
        CFG_NOISE_TH:  noise_threshold <= cfg_data[TH_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // ---------------- position ----------------
  always_comb begin
    if (state == ST_CWAIT) begin
      pos_next = cdiv_q;
    end else if (!m_seen) begin
      pos_next = (last_position < POS_BITS'(POS_MID)) ? '0 : POS_BITS'(POS_MAX);
    end else begin
      pos_next = last_position;
    end
  end

  always_ff @(posedge clk) begin
    if (pos_load) pos <= pos_next;
  end

  // ---------------- PID terms ----------------
  assign gain_eff  = (gain_divider == '0) ? GAIN_BITS'(1) : gain_divider;
  assign err_c     = {1'b0, pos} - {1'b0, setpoint};
  assign err_abs   = err_c[ERR_BITS-1] ? ({ERR_BITS{1'b0}} - err_c) : err_c;
  assign deriv     = {err_c[ERR_BITS-1], err_c} - {last_error[ERR_BITS-1], last_error};
  assign d3        = {{2{deriv[ERR_BITS]}}, deriv} + {deriv[ERR_BITS], deriv, 1'b0};
  // round toward zero before halving
  assign d3r       = d3 + {{(ERR_BITS+2){1'b0}}, d3[ERR_BITS+2]};
  assign integ_sum = {error_integral[INT_BITS-1], error_integral}
                   + {{(INT_BITS+1-ERR_BITS){err_c[ERR_BITS-1]}}, err_c};

  always_comb begin
    if (integ_sum[INT_BITS] != integ_sum[INT_BITS-1]) begin
      integ_sat = integ_sum[INT_BITS] ? {1'b1, {(INT_BITS-1){1'b0}}}
                                      : {1'b0, {(INT_BITS-1){1'b1}}};
    end else begin
      integ_sat = integ_sum[INT_BITS-1:0];
    end
  end

  assign integ_mag = integ_sat[INT_BITS-1] ? ({INT_BITS{1'b0}} - integ_sat) : integ_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_position  <= '0;
      last_error     <= '0;
      error_integral <= '0;
    end else begin
      if ((state == ST_CWAIT) && !cdiv_busy) last_position <= cdiv_q;
      if (pid_load) begin
        last_error     <= err_c;
        error_integral <= integ_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pid_load) begin
      err_neg     <= err_c[ERR_BITS-1];
      integ_neg   <= integ_sat[INT_BITS-1];
      dh          <= d3r[ERR_BITS+2:1];
      integ_mag_q <= integ_mag;
    end
  end

  // integral quotient: reciprocal multiply of the registered magnitude, then registered in idiv_q
  assign integ_prod = {{INTEG_RCP_BITS{1'b0}}, integ_mag_q[INT_BITS-1:INTEG_PRE_SHIFT]}
                    * {{INTEG_RCP_BITS{1'b0}}, INTEG_RCP};

  always_ff @(posedge clk) begin
    idiv_q <= integ_prod[INTEG_RCP_SHIFT+INTEG_Q_BITS-1:INTEG_RCP_SHIFT];
  end

  // ---------------- sum, clamp, duties ----------------
  assign q1e       = {{(DIFF_BITS-POS_BITS){1'b0}}, pdiv_q};
  assign q2e       = {{(DIFF_BITS-INTEG_Q_BITS){1'b0}}, idiv_q};
  assign q1s       = err_neg ? ({DIFF_BITS{1'b0}} - q1e) : q1e;
  assign q2s       = integ_neg ? ({DIFF_BITS{1'b0}} - q2e) : q2e;
  assign dh_ext    = {{(DIFF_BITS-DH_W){dh[DH_W-1]}}, dh};
  assign diff_next = q1s + dh_ext + q2s;

  always_ff @(posedge clk) begin
    if (sum_load) diff <= $signed(diff_next);
  end

  assign top_s = $signed({{(DIFF_BITS-SPEED_BITS){1'b0}}, top_speed});

  always_comb begin
    if (diff > top_s) begin
      clamp = top_s;
    end else if (diff < -top_s) begin
      clamp = -top_s;
    end else begin
      clamp = diff;
    end
    if (clamp[DIFF_BITS-1]) begin
      left_next  = top_speed;
      right_next = top_speed + clamp[SPEED_BITS-1:0];
    end else begin
      left_next  = top_speed - clamp[SPEED_BITS-1:0];
      right_next = top_speed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      left_speed    <= left_next;
      right_speed   <= right_next;
      line_position <= pos;
      line_seen     <= m_seen;
    end
  end

  `ASSERT_IMPLIES(a_lost_pos, result_valid && !line_seen, (line_position == '0) || (line_position == POS_BITS'(POS_MAX)), "lost line gave an interior position")
  `ASSERT_IMPLIES(a_pos_range, result_valid, line_position <= POS_BITS'(POS_MAX), "line position beyond last sensor")
  `ASSERT_IMPLIES(a_idle_divs, state == ST_IDLE, !cdiv_busy && !pdiv_busy, "divider busy while controller idle")

endmodule

`default_nettype wire
